// File: sv/imd_pkg.sv
// Package holding the shared constants, codes and types of the media deframer.
`default_nettype none
package imd_pkg;

    // Longest text response in bytes; the byte that reaches it ends the response.
    localparam int RESPONSE_LIMIT = 4092;
    localparam int TCNT_W         = $clog2(RESPONSE_LIMIT + 1);

    // Depth of the event queue between the front and the back end.
    localparam int QDEPTH = 8;
    localparam int QPTR_W = $clog2(QDEPTH);
    localparam int QCNT_W = $clog2(QDEPTH + 1);

    localparam logic [7:0]  SYNC_AB      = 8'hAB;
    localparam logic [7:0]  SYNC_AA      = 8'hAA;
    localparam logic [7:0]  CHAR_CR      = 8'h0D;
    localparam logic [7:0]  CHAR_LF      = 8'h0A;
    localparam logic [23:0] TAIL_CRLFCR  = 24'h0D0A0D;
    localparam logic [23:0] TAIL_LFCRLF  = 24'h0A0D0A;
    localparam logic [15:0] STYPE_RESET  = 16'd263;

    // Header byte numbers.
    localparam logic [3:0] HDR_LEN_FIRST = 4'd4;
    localparam logic [3:0] HDR_LEN_LAST  = 4'd7;
    localparam logic [3:0] HDR_TYPE_LO   = 4'd8;
    localparam logic [3:0] HDR_TYPE_HI   = 4'd9;
    localparam logic [3:0] HDR_TICK_LO   = 4'd10;
    localparam logic [3:0] HDR_TICK_HI   = 4'd11;

    localparam logic KIND_MEDIA = 1'b0;
    localparam logic KIND_TEXT  = 1'b1;

    typedef enum logic [3:0] {
        PH_GATHER  = 4'b0001,
        PH_HEADER  = 4'b0010,
        PH_PAYLOAD = 4'b0100,
        PH_TEXT    = 4'b1000
    } t_phase;

    // One queued event: either a single result or a whole four-byte group.
    typedef struct packed {
        logic [3:0][7:0] bytes;   // bytes[0] goes out first
        logic            quad;    // four results instead of one
        logic            kind;
        logic            last;    // applies to the final result of the event
        logic [16:0]     tag;
        logic            status;
    } t_event;

endpackage
`default_nettype wire

// File: sv/interleaved_media_deframer.sv
// Top level of the interleaved media deframer: front end, event queue and back end.
// A byte that yields one result passes the event queue and the back-end register
// before it shows on the master side; a completed four-byte group shows its first
// byte the same way and its other bytes after it in order. One input byte per cycle is
// taken while the eight-entry queue has room, set by the single-byte back-end output; the
// queue absorbs group bursts. Reset (synchronous, active low) clears all control state.
`default_nettype none
module interleaved_media_deframer
    import imd_pkg::*;
(
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        s_axis_tvalid,
    output logic             s_axis_tready,
    input  wire logic [23:0] s_axis_tdata,   // [7:0] data_byte, [23:8] tick_stamp
    output logic             m_axis_tvalid,
    input  wire logic        m_axis_tready,
    output logic [31:0]      m_axis_tdata,   // [7:0] out_byte, [24:8] stream_tag,
                                             // [25] status, [31:26] zero
    output logic             m_axis_tuser,   // [0] kind: 0 media, 1 text
    output logic             m_axis_tlast
);

    // The front end takes a request whenever the queue has room; every
    // request that yields results becomes exactly one queued event.
    logic   take;
    logic   push;
    logic   pop;
    logic   q_empty;
    logic   q_full;
    t_event fr_event;
    t_event q_event;

    logic [7:0]  out_byte;
    logic [16:0] out_tag;
    logic        out_status;

    assign s_axis_tready = !q_full;
    assign take          = s_axis_tvalid && !q_full;

    imd_front u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_take       (take),
        .i_data_byte  (s_axis_tdata[7:0]),
        .i_tick_stamp (s_axis_tdata[23:8]),
        .o_push       (push),
        .o_event      (fr_event)
    );

    imd_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_event (fr_event),
        .i_pop   (pop),
        .o_event (q_event),
        .o_empty (q_empty),
        .o_full  (q_full)
    );

    // The back end holds the current event in registers, so the master side
    // is driven straight from flip-flops and stalls independently.
    imd_back u_back (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_event  (q_event),
        .i_empty  (q_empty),
        .o_pop    (pop),
        .i_ready  (m_axis_tready),
        .o_valid  (m_axis_tvalid),
        .o_byte   (out_byte),
        .o_kind   (m_axis_tuser),
        .o_last   (m_axis_tlast),
        .o_tag    (out_tag),
        .o_status (out_status)
    );

    assign m_axis_tdata = {6'd0, out_status, out_tag, out_byte};

endmodule
`default_nettype wire

// File: sv/imd_front.sv
// Front end: gathers sync groups, tracks the packet or response and builds events.
`default_nettype none
module imd_front
    import imd_pkg::*;
(
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_take,
    input  wire logic [7:0]  i_data_byte,
    input  wire logic [15:0] i_tick_stamp,
    output logic             o_push,
    output t_event           o_event
);

    t_phase              r_phase, n_phase;
    logic [2:0][7:0]     r_group, n_group;
    logic [1:0]          r_group_count, n_group_count;
    logic [3:0]          r_hdr_idx, n_hdr_idx;
    logic [31:0]         r_length, n_length;
    logic                r_new_type, n_new_type;
    logic [15:0]         r_stype, n_stype;
    logic [7:0]          r_tick_high, n_tick_high;
    logic [30:0]         r_left, n_left;
    logic [23:0]         r_window, n_window;
    logic [TCNT_W-1:0]   r_text_count, n_text_count;

    logic              sync_ok;
    logic [23:0]       grp_tail;
    logic              text_end;
    logic [31:0]       eff_len;
    logic [TCNT_W-1:0] cnt_inc;
    logic              crlf;
    logic [16:0]       media_tag;

    assign grp_tail  = {r_group[1], r_group[2], i_data_byte};
    assign sync_ok   = (r_group[0] == SYNC_AB || r_group[0] == SYNC_AA) &&
                       r_group[1] == SYNC_AA && r_group[2] == 8'd0 && i_data_byte == 8'd0;
    assign text_end  = r_group[0] == CHAR_CR && grp_tail == TAIL_LFCRLF;
    assign eff_len   = r_length[31] ? 32'd0 : r_length;
    assign cnt_inc   = r_text_count + TCNT_W'(1);
    assign crlf      = r_window == TAIL_CRLFCR && i_data_byte == CHAR_LF;
    assign media_tag = {r_new_type, r_stype};

    always_comb begin
        n_phase       = r_phase;
        n_group       = r_group;
        n_group_count = r_group_count;
        n_hdr_idx     = r_hdr_idx;
        n_length      = r_length;
        n_new_type    = r_new_type;
        n_stype       = r_stype;
        n_tick_high   = r_tick_high;
        n_left        = r_left;
        n_window      = r_window;
        n_text_count  = r_text_count;
        o_push        = 1'b0;
        o_event       = '0;
        o_event.bytes[0] = i_data_byte;

        if (i_take) begin
            unique case (r_phase)
                PH_GATHER: begin
                    if (r_group_count != 2'd3) begin
                        n_group[r_group_count] = i_data_byte;
                        n_group_count          = r_group_count + 2'd1;
                    end else begin
                        n_group_count = 2'd0;
                        o_push        = 1'b1;
                        o_event.quad  = 1'b1;
                        o_event.bytes = {i_data_byte, r_group[2], r_group[1], r_group[0]};
                        if (sync_ok) begin
                            n_new_type = r_group[0] == SYNC_AB;
                            n_length   = '0;
                            n_hdr_idx  = HDR_LEN_FIRST;
                            n_phase    = PH_HEADER;
                            o_event.kind = KIND_MEDIA;
                        end else begin
                            n_text_count = TCNT_W'(4);
                            n_window     = grp_tail;
                            o_event.kind = KIND_TEXT;
                            o_event.last = text_end;
                            n_phase      = text_end ? PH_GATHER : PH_TEXT;
                        end
                    end
                end
                PH_HEADER: begin
                    o_push    = 1'b1;
                    n_hdr_idx = r_hdr_idx + 4'd1;
                    unique case (r_hdr_idx)
                        HDR_TYPE_LO: begin
                            if (r_new_type) begin
                                n_stype[7:0] = i_data_byte;
                            end
                            o_event.bytes[0] = r_new_type ? i_data_byte : r_stype[7:0];
                        end
                        HDR_TYPE_HI: begin
                            if (r_new_type) begin
                                n_stype[15:8] = i_data_byte;
                            end
                            o_event.bytes[0] = r_new_type ? i_data_byte : r_stype[15:8];
                        end
                        HDR_TICK_LO: begin
                            o_event.bytes[0] = i_tick_stamp[7:0];
                            n_tick_high      = i_tick_stamp[15:8];
                        end
                        HDR_TICK_HI: begin
                            o_event.bytes[0] = r_tick_high;
                            if (eff_len == 32'd0) begin
                                o_event.last = 1'b1;
                                o_event.tag  = media_tag;
                                n_phase      = PH_GATHER;
                            end else begin
                                n_left  = eff_len[30:0];
                                n_phase = PH_PAYLOAD;
                            end
                        end
                        default: begin
                            // Length bytes, little-endian.
                            n_length[8*r_hdr_idx[1:0] +: 8] = i_data_byte;
                        end
                    endcase
                end
                PH_PAYLOAD: begin
                    o_push = 1'b1;
                    n_left = r_left - 31'd1;
                    if (r_left == 31'd1) begin
                        o_event.last = 1'b1;
                        o_event.tag  = media_tag;
                        n_phase      = PH_GATHER;
                    end
                end
                PH_TEXT: begin
                    o_push       = 1'b1;
                    o_event.kind = KIND_TEXT;
                    n_text_count = cnt_inc;
                    n_window     = {r_window[15:0], i_data_byte};
                    if (cnt_inc >= TCNT_W'(RESPONSE_LIMIT)) begin
                        o_event.last   = 1'b1;
                        o_event.status = 1'b1;
                        n_phase        = PH_GATHER;
                    end else if (crlf) begin
                        o_event.last = 1'b1;
                        n_phase      = PH_GATHER;
                    end
                end
                default: begin
                    n_phase = PH_GATHER;
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase       <= PH_GATHER;
            r_group       <= '0;
            r_group_count <= '0;
            r_hdr_idx     <= '0;
            r_length      <= '0;
            r_new_type    <= 1'b0;
            r_stype       <= STYPE_RESET;
            r_tick_high   <= '0;
            r_left        <= '0;
            r_window      <= '0;
            r_text_count  <= '0;
        end else begin
            r_phase       <= n_phase;
            r_group       <= n_group;
            r_group_count <= n_group_count;
            r_hdr_idx     <= n_hdr_idx;
            r_length      <= n_length;
            r_new_type    <= n_new_type;
            r_stype       <= n_stype;
            r_tick_high   <= n_tick_high;
            r_left        <= n_left;
            r_window      <= n_window;
            r_text_count  <= n_text_count;
        end
    end

    // The header walk stays on the bytes after the sync group.
    a_hdr_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_phase == PH_HEADER |-> r_hdr_idx >= HDR_LEN_FIRST && r_hdr_idx <= HDR_TICK_HI)
        else $error("header index out of range");
    // A payload never runs with nothing left to send.
    a_left_nonzero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_phase == PH_PAYLOAD |-> r_left != 31'd0)
        else $error("payload phase with zero bytes left");

endmodule
`default_nettype wire

// File: sv/imd_queue.sv
// Event queue between the front and the back end.
`default_nettype none
module imd_queue
    import imd_pkg::*;
(
    input  wire logic   i_clk,
    input  wire logic   i_rst_n,
    input  wire logic   i_push,
    input  t_event      i_event,
    input  wire logic   i_pop,
    output t_event      o_event,
    output logic        o_empty,
    output logic        o_full
);

    t_event              r_mem [QDEPTH];
    logic [QPTR_W-1:0]   r_wr_ptr;
    logic [QPTR_W-1:0]   r_rd_ptr;
    logic [QCNT_W-1:0]   r_count;

    assign o_empty = r_count == QCNT_W'(0);
    assign o_full  = r_count == QCNT_W'(QDEPTH);
    assign o_event = r_mem[r_rd_ptr];

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_event;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= r_wr_ptr + QPTR_W'(1);
            end
            if (i_pop) begin
                r_rd_ptr <= r_rd_ptr + QPTR_W'(1);
            end
            r_count <= r_count + QCNT_W'(i_push) - QCNT_W'(i_pop);
        end
    end

    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_full |-> !i_push || i_pop)
        else $error("push into a full queue");
    a_no_underflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_empty |-> !i_pop)
        else $error("pop from an empty queue");

endmodule
`default_nettype wire

// File: sv/imd_back.sv
// Back end: holds one event and sends its results out one byte per request.
`default_nettype none
module imd_back
    import imd_pkg::*;
(
    input  wire logic   i_clk,
    input  wire logic   i_rst_n,
    input  t_event      i_event,
    input  wire logic   i_empty,
    output logic        o_pop,
    input  wire logic   i_ready,
    output logic        o_valid,
    output logic [7:0]  o_byte,
    output logic        o_kind,
    output logic        o_last,
    output logic [16:0] o_tag,
    output logic        o_status
);

    t_event     r_ev;
    logic       r_ev_valid;
    logic [1:0] r_idx;
    logic       fire;
    logic       ev_done;

    assign fire    = r_ev_valid && i_ready;
    assign ev_done = !r_ev.quad || r_idx == 2'd3;
    assign o_pop   = !i_empty && (!r_ev_valid || (fire && ev_done));

    assign o_valid  = r_ev_valid;
    assign o_byte   = r_ev.bytes[r_idx];
    assign o_kind   = r_ev.kind;
    assign o_last   = r_ev.last && ev_done;
    assign o_tag    = r_ev.tag;
    assign o_status = r_ev.status;

    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_ev <= i_event;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ev_valid <= 1'b0;
            r_idx      <= '0;
        end else if (o_pop) begin
            r_ev_valid <= 1'b1;
            r_idx      <= '0;
        end else if (fire) begin
            if (ev_done) begin
                r_ev_valid <= 1'b0;
            end else begin
                r_idx <= r_idx + 2'd1;
            end
        end
    end

    a_status_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_status |-> o_last && o_kind == KIND_TEXT)
        else $error("overflow status away from the end of a response");
    a_tag_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_tag != 17'd0 |-> o_last && o_kind == KIND_MEDIA)
        else $error("stream tag away from the end of a packet");

endmodule
`default_nettype wire
